>>> rtl/mrsf_pkg.sv
// ----------------------------------------------------------------------------
// mrsf_pkg
// Shared types, constants and the exp root table for the regime filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mrsf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int REGIMES   = 9;
    localparam int FEAT_W    = 24;
    localparam int POST_W    = 17;
    localparam int LOGIT_W   = 40;
    localparam int DVD_W     = LOGIT_W + 8;
    localparam int DVS_W     = 34;
    localparam int Z_W       = 54;
    localparam int TEMP_W    = 16;

    localparam logic [TEMP_W-1:0] TEMP_RESET  = 16'd256;
    localparam logic [POST_W-1:0] UNIFORM_Q16 = 17'd7282;
    localparam logic [POST_W-1:0] POST_ONE    = 17'd65536;
    localparam logic [21:0]       D_MAX       = 22'd2097152;
    localparam logic [33:0]       LN2_Q16     = 34'd45426;
    localparam logic [33:0]       LOG2E_Q16   = 34'd94548;
    localparam logic [33:0]       K015_Q16    = 34'd9830;

    typedef struct packed {
        logic signed [FEAT_W-1:0] spread_press;
        logic signed [FEAT_W-1:0] cxl_add_ratio;
        logic signed [FEAT_W-1:0] aggressor_imbalance;
        logic signed [FEAT_W-1:0] slope_delta;
        logic signed [FEAT_W-1:0] vacuum_score;
        logic signed [FEAT_W-1:0] touch_cxl;
        logic [1:0]               event_class;
    } in_t;

    typedef struct packed {
        logic [POST_W-1:0] post_normal;
        logic [POST_W-1:0] post_event_shock;
        logic [POST_W-1:0] post_vacuum;
        logic [POST_W-1:0] post_stop_cascade;
        logic [POST_W-1:0] post_prop_flatten;
        logic [POST_W-1:0] post_book_rebuild;
        logic [POST_W-1:0] post_chop;
        logic [POST_W-1:0] post_trend;
        logic [POST_W-1:0] post_spread_press;
    } out_t;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SHOCK   = 2'd1;
    localparam logic [1:0] EV_FLATTEN = 2'd2;
    localparam logic [1:0] EV_NEWS    = 2'd3;

    typedef logic signed [LOGIT_W-1:0] logit_t;
    typedef logit_t [REGIMES-1:0] logit_vec_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef logic [31:0] root_tab_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int k = 0; k < 16; k++)
        begin
            tab[k] = r[31:0];
            r = isqrt64(r << 30);
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

`default_nettype wire

>>> rtl/mrsf_div.sv
// ----------------------------------------------------------------------------
// mrsf_div
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsf_div (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mrsf_pkg::div_req_t  req,
    output mrsf_pkg::div_rsp_t  rsp
);

    localparam int DVD_W = mrsf_pkg::DVD_W;
    localparam int DVS_W = mrsf_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   rem_s;
    logic             ge;
    logic [DVS_W:0]   rem_d;

    always_comb
    begin
        rem_s = {rem_reg, quo_reg[DVD_W-1]};
        ge    = rem_s >= {1'b0, dvs_reg};
        rem_d = ge ? rem_s - {1'b0, dvs_reg} : rem_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_d[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/mrsf_front.sv
// ----------------------------------------------------------------------------
// mrsf_front
// Accepts feature items and forms the nine boosted regime logits.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsf_front #(
    parameter int FRAC_BITS = mrsf_pkg::FRAC_BITS
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   item_valid,
    output logic                  item_stall,
    input  mrsf_pkg::in_t         item,
    output logic                  push,
    output mrsf_pkg::logit_vec_t  push_data,
    input  wire                   q_ready
);

    localparam int LW = mrsf_pkg::LOGIT_W;
    localparam int PW = 2 * mrsf_pkg::FEAT_W + 1;

    localparam logic signed [LW-1:0] ONE    = LW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [LW-1:0] HALF   = LW'((64'sd1 <<< FRAC_BITS) / 2);
    localparam logic signed [LW-1:0] ONE_P5 = LW'(3 * (64'sd1 <<< FRAC_BITS) / 2);
    localparam logic signed [LW-1:0] ONE_P2 = LW'((12 * (64'sd1 <<< FRAC_BITS) + 5) / 10);
    localparam logic signed [LW-1:0] TWO    = LW'(2 * (64'sd1 <<< FRAC_BITS));
    localparam logic signed [LW-1:0] THREE  = LW'(3 * (64'sd1 <<< FRAC_BITS));

    logic                 valid_reg;
    mrsf_pkg::logit_vec_t lg_reg;
    mrsf_pkg::logit_vec_t lg;

    logic signed [LW-1:0] ss, cr, ai, sc, vs, nc;
    logic signed [LW-1:0] mag_ai, mag_sc;
    logic signed [LW-1:0] ss_m1, ss_m15, cr_m15, ss_m12;
    logic signed [LW-1:0] pos_ss1, pos_ss15, pos_cr15, pos_ss12;
    logic signed [PW-2:0] prod;
    logic signed [PW-1:0] nprod;
    logic signed [PW-1:0] nshift;
    logic                 accept;

    always_comb
    begin
        ss = LW'(item.spread_press);
        cr = LW'(item.cxl_add_ratio);
        ai = LW'(item.aggressor_imbalance);
        sc = LW'(item.slope_delta);
        vs = LW'(item.vacuum_score);
        nc = LW'(item.touch_cxl);

        mag_ai = ai[LW-1] ? -ai : ai;
        mag_sc = sc[LW-1] ? -sc : sc;

        ss_m1  = ss - ONE;
        ss_m15 = ss - ONE_P5;
        cr_m15 = cr - ONE_P5;
        ss_m12 = ss - ONE_P2;
        pos_ss1  = (ss_m1  > 0) ? ss_m1  : '0;
        pos_ss15 = (ss_m15 > 0) ? ss_m15 : '0;
        pos_cr15 = (cr_m15 > 0) ? cr_m15 : '0;
        pos_ss12 = (ss_m12 > 0) ? ss_m12 : '0;

        prod   = item.slope_delta * item.aggressor_imbalance;
        nprod  = -PW'(prod);
        nshift = nprod >>> FRAC_BITS;

        lg[0] = -mag_ai - pos_ss1;
        lg[1] = pos_ss15 + 2 * mag_sc;
        lg[2] = 3 * vs + pos_ss1;
        lg[3] = 2 * mag_ai + pos_cr15;
        lg[4] = '0;
        lg[5] = (nshift > 0) ? LW'(nshift) : '0;
        lg[6] = -mag_ai + (mag_sc >>> 1);
        lg[7] = ((3 * mag_ai) >>> 1) - mag_sc;
        lg[8] = 2 * pos_ss12;

        case (item.event_class)
            mrsf_pkg::EV_SHOCK:
            begin
                lg[1] = lg[1] + TWO;
                lg[8] = lg[8] + ONE;
            end
            mrsf_pkg::EV_FLATTEN:
            begin
                lg[4] = lg[4] + THREE;
                lg[0] = lg[0] - ONE;
            end
            mrsf_pkg::EV_NEWS:
            begin
                lg[4] = lg[4] + ONE_P5;
            end
            default:
            begin
            end
        endcase

        if (nc > HALF)
        begin
            lg[1] = lg[1] + HALF;
            lg[2] = lg[2] + HALF;
        end
    end

    assign push       = valid_reg && q_ready;
    assign item_stall = valid_reg && !q_ready;
    assign accept     = item_valid && !item_stall;
    assign push_data  = lg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lg_reg <= lg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrsf_queue.sv
// ----------------------------------------------------------------------------
// mrsf_queue
// Two-entry queue of logit vectors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsf_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  mrsf_pkg::logit_vec_t  push_data,
    output logic                  ready,
    input  wire                   pop,
    output logic                  valid,
    output mrsf_pkg::logit_vec_t  data
);

    mrsf_pkg::logit_vec_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign ready = count_reg != 2'd2;
    assign valid = count_reg != 2'd0;
    assign data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrsf_back.sv
// ----------------------------------------------------------------------------
// mrsf_back
// Sequencer for log prior, temperature scale, exp and normalize per item.
// ----------------------------------------------------------------------------
`default_nettype none

module mrsf_back #(
    parameter int FRAC_BITS = mrsf_pkg::FRAC_BITS
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           q_valid,
    input  mrsf_pkg::logit_vec_t          q_data,
    output logic                          q_pop,
    input  wire [mrsf_pkg::TEMP_W-1:0]    temperature,
    output mrsf_pkg::div_req_t            div_req,
    input  mrsf_pkg::div_rsp_t            div_rsp,
    output logic                          post_valid,
    input  wire                           post_stall,
    output mrsf_pkg::out_t                post
);

    localparam int LW  = mrsf_pkg::LOGIT_W;
    localparam int ZW  = mrsf_pkg::Z_W;
    localparam int PW  = mrsf_pkg::POST_W;
    localparam int NR  = mrsf_pkg::REGIMES;
    localparam int T_UP = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int T_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD     = 4'd1;
    localparam logic [3:0] S_LSQ_M    = 4'd2;
    localparam logic [3:0] S_LSQ_A    = 4'd3;
    localparam logic [3:0] S_LN_M1    = 4'd4;
    localparam logic [3:0] S_LN_M2    = 4'd5;
    localparam logic [3:0] S_LN_A     = 4'd6;
    localparam logic [3:0] S_DIV_Z    = 4'd7;
    localparam logic [3:0] S_EXP_M    = 4'd8;
    localparam logic [3:0] S_EXP_T    = 4'd9;
    localparam logic [3:0] S_EXP_STEP = 4'd10;
    localparam logic [3:0] S_EXP_A    = 4'd11;
    localparam logic [3:0] S_EXP_END  = 4'd12;
    localparam logic [3:0] S_POST_GO  = 4'd13;
    localparam logic [3:0] S_POST_W   = 4'd14;
    localparam logic [3:0] S_OUT      = 4'd15;

    localparam logic [3:0] LAST_IDX = 4'(NR - 1);

    logic [3:0]              state_reg;
    logic [3:0]              idx_reg;
    logic [3:0]              cnt_reg;
    logic [PW-1:0]           prior_reg [NR];
    logic                    post_valid_reg;

    mrsf_pkg::logit_vec_t    lg_reg;
    logic signed [ZW-1:0]    z_reg [NR];
    logic signed [ZW-1:0]    zmax_reg;
    logic [30:0]             ex_reg [NR];
    logic [33:0]             sum_reg;
    logic [31:0]             x_reg;
    logic [4:0]              e_reg;
    logic [15:0]             frac_reg;
    logic [5:0]              n_reg;
    logic [15:0]             f_reg;
    logic                    neg_reg;
    logic [PW-1:0]           res_reg [NR];
    mrsf_pkg::out_t          post_reg;
    logic signed [67:0]      prod_reg;

    logic [PW-1:0]           p_sel;
    logic [4:0]              e_val;
    logic [31:0]             x_load;
    logic [31:0]             sq;
    logic signed [21:0]      l2;
    logic signed [LW-1:0]    term_w;
    logic signed [LW-1:0]    term_f;
    logic signed [LW-1:0]    v;
    logic [LW-1:0]           vmag;
    logic [15:0]             temp_eff;
    logic signed [ZW-1:0]    zq;
    logic signed [ZW-1:0]    zs;
    logic signed [ZW:0]      d;
    logic [21:0]             dc;
    logic [30:0]             ex_val;
    logic [PW-1:0]           p_out;
    logic signed [33:0]      mul_a;
    logic signed [33:0]      mul_b;
    logic                    out_free;

    always_comb
    begin
        p_sel = (prior_reg[idx_reg] == '0) ? PW'(1) : prior_reg[idx_reg];
        e_val = 5'd0;
        for (int b = 0; b < PW; b++)
        begin
            if (p_sel[b])
            begin
                e_val = 5'(b);
            end
        end
        x_load = 32'(p_sel) << (5'd30 - e_val);
        sq     = prod_reg[61:30];
        l2     = {6'({1'b0, e_reg}) - 6'd16, frac_reg};

        term_w = LW'(prod_reg >>> 16);
        term_f = (term_w <<< T_UP) >>> T_DN;
        v      = lg_reg[idx_reg] + term_f;
        vmag   = v[LW-1] ? LW'(-v) : LW'(v);
        temp_eff = (temperature == '0) ? 16'd1 : temperature;

        zq = neg_reg ? -$signed(ZW'(div_rsp.quotient)) : $signed(ZW'(div_rsp.quotient));
        zs = (zq <<< T_DN) >>> T_UP;

        d  = (ZW+1)'(zmax_reg) - (ZW+1)'(z_reg[idx_reg]);
        dc = (d > (ZW+1)'(mrsf_pkg::D_MAX)) ? mrsf_pkg::D_MAX : d[21:0];
        ex_val = (n_reg > 6'd30) ? 31'd0 : 31'(x_reg >> n_reg);
        p_out  = (div_rsp.quotient > 48'(mrsf_pkg::POST_ONE)) ? mrsf_pkg::POST_ONE
                                                              : div_rsp.quotient[PW-1:0];

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LSQ_M:
            begin
                mul_a = $signed({2'b00, x_reg});
                mul_b = $signed({2'b00, x_reg});
            end
            S_LN_M1:
            begin
                mul_a = 34'(l2);
                mul_b = $signed(mrsf_pkg::LN2_Q16);
            end
            S_LN_M2:
            begin
                mul_a = 34'(prod_reg >>> 16);
                mul_b = $signed(mrsf_pkg::K015_Q16);
            end
            S_EXP_M:
            begin
                mul_a = $signed({12'd0, dc});
                mul_b = $signed(mrsf_pkg::LOG2E_Q16);
            end
            S_EXP_STEP:
            begin
                mul_a = $signed({2'b00, x_reg});
                mul_b = $signed({2'b00, mrsf_pkg::ROOT_TAB[cnt_reg]});
            end
            default:
            begin
            end
        endcase

        div_req.start    = (state_reg == S_LN_A) || (state_reg == S_POST_GO);
        div_req.dividend = (state_reg == S_LN_A) ? {vmag, 8'd0}
                         : 48'({ex_reg[idx_reg], 16'd0}) + 48'(sum_reg >> 1);
        div_req.divisor  = (state_reg == S_LN_A) ? 34'(temp_eff) : sum_reg;
    end

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !post_valid_reg || !post_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            post_valid_reg <= 1'b0;
            for (int i = 0; i < NR; i++)
            begin
                prior_reg[i] <= mrsf_pkg::UNIFORM_Q16;
            end
        end
        else
        begin
            if (post_valid_reg && !post_stall && !((state_reg == S_OUT) && out_free))
            begin
                post_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_LSQ_M;
                end
                S_LSQ_M:
                begin
                    state_reg <= S_LSQ_A;
                end
                S_LSQ_A:
                begin
                    cnt_reg   <= cnt_reg + 4'd1;
                    state_reg <= (cnt_reg == 4'd15) ? S_LN_M1 : S_LSQ_M;
                end
                S_LN_M1:
                begin
                    state_reg <= S_LN_M2;
                end
                S_LN_M2:
                begin
                    state_reg <= S_LN_A;
                end
                S_LN_A:
                begin
                    state_reg <= S_DIV_Z;
                end
                S_DIV_Z:
                begin
                    if (div_rsp.done)
                    begin
                        if (idx_reg == LAST_IDX)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_EXP_M;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_EXP_M:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_EXP_T;
                end
                S_EXP_T:
                begin
                    state_reg <= S_EXP_STEP;
                end
                S_EXP_STEP:
                begin
                    if (f_reg[4'd15 - cnt_reg])
                    begin
                        state_reg <= S_EXP_A;
                    end
                    else if (cnt_reg == 4'd15)
                    begin
                        state_reg <= S_EXP_END;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_EXP_A:
                begin
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= S_EXP_END;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 4'd1;
                        state_reg <= S_EXP_STEP;
                    end
                end
                S_EXP_END:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_POST_GO;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= S_EXP_M;
                    end
                end
                S_POST_GO:
                begin
                    state_reg <= S_POST_W;
                end
                S_POST_W:
                begin
                    if (div_rsp.done)
                    begin
                        prior_reg[idx_reg] <= p_out;
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 4'd1;
                            state_reg <= S_POST_GO;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        post_valid_reg <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                lg_reg <= q_data;
            end
            S_LOAD:
            begin
                x_reg    <= x_load;
                e_reg    <= e_val;
                frac_reg <= '0;
            end
            S_LSQ_A:
            begin
                frac_reg <= {frac_reg[14:0], sq[31]};
                x_reg    <= sq[31] ? (sq >> 1) : sq;
            end
            S_LN_A:
            begin
                neg_reg <= v[LW-1];
            end
            S_DIV_Z:
            begin
                if (div_rsp.done)
                begin
                    z_reg[idx_reg] <= zs;
                    if ((idx_reg == '0) || (zs > zmax_reg))
                    begin
                        zmax_reg <= zs;
                    end
                    sum_reg <= '0;
                end
            end
            S_EXP_T:
            begin
                n_reg <= prod_reg[37:32];
                f_reg <= prod_reg[31:16];
                x_reg <= 32'd1 << 30;
            end
            S_EXP_A:
            begin
                x_reg <= prod_reg[61:30];
            end
            S_EXP_END:
            begin
                ex_reg[idx_reg] <= ex_val;
                sum_reg         <= sum_reg + 34'(ex_val);
            end
            S_POST_W:
            begin
                if (div_rsp.done)
                begin
                    res_reg[idx_reg] <= p_out;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    post_reg.post_normal        <= res_reg[0];
                    post_reg.post_event_shock   <= res_reg[1];
                    post_reg.post_vacuum        <= res_reg[2];
                    post_reg.post_stop_cascade  <= res_reg[3];
                    post_reg.post_prop_flatten  <= res_reg[4];
                    post_reg.post_book_rebuild  <= res_reg[5];
                    post_reg.post_chop          <= res_reg[6];
                    post_reg.post_trend         <= res_reg[7];
                    post_reg.post_spread_press  <= res_reg[8];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign post_valid = post_valid_reg;
    assign post       = post_reg;

endmodule

`default_nettype wire

>>> rtl/market_regime_softmax_filter.sv
// ----------------------------------------------------------------------------
// market_regime_softmax_filter
// Nine-regime softmax posterior filter over order-book feature items.
// ----------------------------------------------------------------------------
// Each item yields one result of nine Q1.16 posteriors. The back end makes
// eighteen passes through the shared radix-2 divider (nine temperature
// scalings, nine normalizations), sixteen squaring steps per log and up
// to 16 root multiplies per exp on the one shared multiplier. The front end
// computes logits combinationally and registers them, and a two-item queue
// lets it take items while the back end works; the output register holds a
// result while the next item runs. Temperature is written through cfg_we and
// cfg_wdata; the user must write it only while idle, which the block itself
// does not enforce.
`default_nettype none

module market_regime_softmax_filter #(
    parameter int FRAC_BITS = mrsf_pkg::FRAC_BITS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [mrsf_pkg::TEMP_W-1:0]       cfg_wdata,
    input  wire                              item_valid,
    output logic                             item_stall,
    input  mrsf_pkg::in_t                    item,
    output logic                             post_valid,
    input  wire                              post_stall,
    output mrsf_pkg::out_t                   post
);

    logic [mrsf_pkg::TEMP_W-1:0] temperature_reg;

    logic                 push;
    mrsf_pkg::logit_vec_t push_data;
    logic                 q_ready;
    logic                 q_valid;
    logic                 q_pop;
    mrsf_pkg::logit_vec_t q_data;
    mrsf_pkg::div_req_t   div_req;
    mrsf_pkg::div_rsp_t   div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temperature_reg <= mrsf_pkg::TEMP_RESET;
        end
        else if (cfg_we)
        begin
            temperature_reg <= cfg_wdata;
        end
    end

    mrsf_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .q_ready    (q_ready)
    );

    mrsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    mrsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mrsf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .temperature (temperature_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .post_valid  (post_valid),
        .post_stall  (post_stall),
        .post        (post)
    );

endmodule

`default_nettype wire
